// ===== hdl/box_vs_tilemap_collision_unit_macros.svh =====
// Assertion helpers shared by the collision unit's top, divider and sequencer modules.
// Each expects aclk and aresetn in the scope where it is used.
`ifndef BOX_VS_TILEMAP_COLLISION_UNIT_MACROS_SVH
`define BOX_VS_TILEMAP_COLLISION_UNIT_MACROS_SVH

// Same-cycle implication.
`define BVTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BVTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bvtc_pkg.sv =====
package bvtc_pkg;

    // Defaults for the top-level parameters
    localparam int SCREEN_GRID_DEF   = 16;
    localparam int TILE_MAP_SIDE_DEF = 512;

    // Field widths
    localparam int POS_W      = 16;
    localparam int SIZE_W     = 8;
    localparam int CELL_W     = 9;
    localparam int OPC_W      = 2;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int TILE_SHIFT = 3;              // 8x8 pixel tiles
    localparam int TILE_W     = POS_W - TILE_SHIFT;

    // Stream packing
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 8;
    localparam int PX_LSB     = 0;
    localparam int PY_LSB     = PX_LSB + POS_W;
    localparam int BW_LSB     = PY_LSB + POS_W;
    localparam int BH_LSB     = BW_LSB + SIZE_W;
    localparam int CX_LSB     = BH_LSB + SIZE_W;
    localparam int CY_LSB     = CX_LSB + CELL_W;
    localparam int BV_LSB     = CY_LSB + CELL_W;

    // Divider
    localparam int DIV_STEPS  = POS_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Opcodes
    localparam logic [OPC_W-1:0] OP_WR_SCREEN = 2'd0;
    localparam logic [OPC_W-1:0] OP_WR_TILE   = 2'd1;
    localparam logic [OPC_W-1:0] OP_QUERY     = 2'd2;

    // Config registers
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     SCREEN_W_RST      = 8'd128;
    localparam logic [CFG_W-1:0]     SCREEN_H_RST      = 8'd128;

    // Micro-operations
    typedef enum logic [4:0] {
        UOP_CLEAR,
        UOP_ACCEPT,
        UOP_NOP,
        UOP_PREP,
        UOP_DIV_START,
        UOP_DIV_WAIT,
        UOP_SCR_INIT,
        UOP_SCR_SCAN,
        UOP_TILE_INIT,
        UOP_ROW_READ,
        UOP_TILE_SCAN,
        UOP_TILE_NEXT_Y,
        UOP_SET_FREE,
        UOP_EMIT,
        UOP_WR_SCREEN,
        UOP_WR_TILE
    } uop_t;

    // Jump conditions
    typedef enum logic [4:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_CLR_MORE,
        COND_NO_REQ,
        COND_OP_SCREEN,
        COND_OP_TILE,
        COND_NOT_QUERY,
        COND_BAD_SIZE,
        COND_DIV_BUSY,
        COND_SCR_EMPTY,
        COND_SCR_OOR,
        COND_SCR_STEP,
        COND_SCR_MISS,
        COND_TILE_EMPTY,
        COND_X_STEP,
        COND_TILE_SOLID,
        COND_Y_MORE,
        COND_OUT_FULL
    } cond_t;

    typedef enum logic [1:0] {
        DIV_C0,
        DIV_C1,
        DIV_R0,
        DIV_R1
    } div_sel_t;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    typedef struct packed {
        uop_t     uop;
        cond_t    cond;
        div_sel_t dsel;
        pc_t      target;
    } ucode_t;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic clr_more;
        logic no_req;
        logic op_screen;
        logic op_tile;
        logic not_query;
        logic bad_size;
        logic div_busy;
        logic scr_empty;
        logic scr_oor;
        logic scr_step;
        logic scr_miss;
        logic tile_empty;
        logic x_step;
        logic tile_solid;
        logic y_more;
        logic out_full;
    } flags_t;

    // Tile memory command
    typedef struct packed {
        logic clr;
        logic wr;
        logic rd;
        logic bit_val;
    } tmem_cmd_t;

    // Program addresses
    localparam pc_t PC_CLEAR  = 5'd0;
    localparam pc_t PC_ACCEPT = 5'd1;
    localparam pc_t PC_SINIT  = 5'd14;
    localparam pc_t PC_SSCAN  = 5'd16;
    localparam pc_t PC_TINIT  = 5'd18;
    localparam pc_t PC_ROW    = 5'd19;
    localparam pc_t PC_TSCAN  = 5'd20;
    localparam pc_t PC_FREE   = 5'd23;
    localparam pc_t PC_EMIT   = 5'd24;
    localparam pc_t PC_WSCR   = 5'd26;
    localparam pc_t PC_WTILE  = 5'd27;
    localparam pc_t PC_LAST   = PC_WTILE;

    function automatic ucode_t mk_uw(uop_t u, cond_t c, div_sel_t d, pc_t t);
        ucode_t w;
        w.uop    = u;
        w.cond   = c;
        w.dsel   = d;
        w.target = t;
        return w;
    endfunction

    // Control store
    function automatic ucode_t ucode_rom(pc_t pc);
        ucode_t w;
        case (pc)
            5'd0:  w = mk_uw(UOP_CLEAR,       COND_CLR_MORE,   DIV_C0, PC_CLEAR);
            5'd1:  w = mk_uw(UOP_ACCEPT,      COND_NO_REQ,     DIV_C0, PC_ACCEPT);
            5'd2:  w = mk_uw(UOP_NOP,         COND_OP_SCREEN,  DIV_C0, PC_WSCR);
            5'd3:  w = mk_uw(UOP_NOP,         COND_OP_TILE,    DIV_C0, PC_WTILE);
            5'd4:  w = mk_uw(UOP_NOP,         COND_NOT_QUERY,  DIV_C0, PC_ACCEPT);
            5'd5:  w = mk_uw(UOP_PREP,        COND_BAD_SIZE,   DIV_C0, PC_EMIT);
            5'd6:  w = mk_uw(UOP_DIV_START,   COND_NEVER,      DIV_C0, PC_CLEAR);
            5'd7:  w = mk_uw(UOP_DIV_WAIT,    COND_DIV_BUSY,   DIV_C0, 5'd7);
            5'd8:  w = mk_uw(UOP_DIV_START,   COND_NEVER,      DIV_C1, PC_CLEAR);
            5'd9:  w = mk_uw(UOP_DIV_WAIT,    COND_DIV_BUSY,   DIV_C1, 5'd9);
            5'd10: w = mk_uw(UOP_DIV_START,   COND_NEVER,      DIV_R0, PC_CLEAR);
            5'd11: w = mk_uw(UOP_DIV_WAIT,    COND_DIV_BUSY,   DIV_R0, 5'd11);
            5'd12: w = mk_uw(UOP_DIV_START,   COND_NEVER,      DIV_R1, PC_CLEAR);
            5'd13: w = mk_uw(UOP_DIV_WAIT,    COND_DIV_BUSY,   DIV_R1, 5'd13);
            5'd14: w = mk_uw(UOP_SCR_INIT,    COND_SCR_EMPTY,  DIV_C0, PC_TINIT);
            5'd15: w = mk_uw(UOP_NOP,         COND_SCR_OOR,    DIV_C0, PC_EMIT);
            5'd16: w = mk_uw(UOP_SCR_SCAN,    COND_SCR_STEP,   DIV_C0, PC_SSCAN);
            5'd17: w = mk_uw(UOP_NOP,         COND_SCR_MISS,   DIV_C0, PC_EMIT);
            5'd18: w = mk_uw(UOP_TILE_INIT,   COND_TILE_EMPTY, DIV_C0, PC_FREE);
            5'd19: w = mk_uw(UOP_ROW_READ,    COND_NEVER,      DIV_C0, PC_CLEAR);
            5'd20: w = mk_uw(UOP_TILE_SCAN,   COND_X_STEP,     DIV_C0, PC_TSCAN);
            5'd21: w = mk_uw(UOP_NOP,         COND_TILE_SOLID, DIV_C0, PC_EMIT);
            5'd22: w = mk_uw(UOP_TILE_NEXT_Y, COND_Y_MORE,     DIV_C0, PC_ROW);
            5'd23: w = mk_uw(UOP_SET_FREE,    COND_NEVER,      DIV_C0, PC_CLEAR);
            5'd24: w = mk_uw(UOP_EMIT,        COND_OUT_FULL,   DIV_C0, PC_EMIT);
            5'd25: w = mk_uw(UOP_NOP,         COND_ALWAYS,     DIV_C0, PC_ACCEPT);
            5'd26: w = mk_uw(UOP_WR_SCREEN,   COND_ALWAYS,     DIV_C0, PC_ACCEPT);
            5'd27: w = mk_uw(UOP_WR_TILE,     COND_ALWAYS,     DIV_C0, PC_ACCEPT);
            default: w = mk_uw(UOP_NOP,       COND_ALWAYS,     DIV_C0, PC_ACCEPT);
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/box_vs_tilemap_collision_unit.sv =====
// Box versus tile map collision check.
// Requests arrive on the s_ stream: s_tuser carries the opcode (write screen bit,
// write solid tile bit, query box), s_tdata the box and cell fields. Each query
// returns one m_ stream item whose bit 0 is 1 when the box lies on existing
// screens and touches no solid 8x8 tile; writes return nothing.
// Screen size registers are written on the cfg_ channel (index 0 width, 1 height);
// the user must write them only while no request is in flight; the block does not enforce it.
// A query runs four divisions on the shared divider, then scans the covered
// screens, then the covered tile rows, one tile per cycle off a registered
// tile-map row (one memory read per row).
// Reset: the screen map clears at once; the tile map is cleared row by row,
// during which s_tready stays low.
// The result sits in an output register; while the receiver stalls, requests
// keep flowing until the next query reaches its emit step, which then waits.
`include "box_vs_tilemap_collision_unit_macros.svh"

module box_vs_tilemap_collision_unit
    import bvtc_pkg::*;
#(
    parameter int SCREEN_GRID   = SCREEN_GRID_DEF,
    parameter int TILE_MAP_SIDE = TILE_MAP_SIDE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pos_x[15:0], pos_y[31:16], box_width[39:32], box_height[47:40],
    // cell_x[56:48], cell_y[65:57], bit_value[66], zero[71:67]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [OPC_W-1:0]     s_tuser,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // box_free[0], zero[7:1]
    output logic [M_TDATA_W-1:0] m_tdata,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int GW    = (SCREEN_GRID > 1) ? $clog2(SCREEN_GRID) : 1;
    localparam int SCR_N = SCREEN_GRID * SCREEN_GRID;
    localparam int SIW   = (SCR_N > 1) ? $clog2(SCR_N) : 1;
    localparam int TW    = $clog2(TILE_MAP_SIDE);

    ucode_t ctrl;
    flags_t flags;

    // config
    logic [CFG_W-1:0] sw_reg, sw_next, sh_reg, sh_next;

    // latched request
    logic [OPC_W-1:0]  op_reg, op_next;
    logic [POS_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic [SIZE_W-1:0] bw_reg, bw_next, bh_reg, bh_next;
    logic [CELL_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic              bv_reg, bv_next;

    // query working registers
    logic [POS_W-1:0]  x1_reg, x1_next, y1_reg, y1_next;
    logic [POS_W-1:0]  c0_reg, c0_next, c1_reg, c1_next;
    logic [POS_W-1:0]  r0_reg, r0_next, r1_reg, r1_next;
    logic [GW-1:0]     col_reg, col_next, row_reg, row_next;
    logic [TILE_W-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic              free_reg, free_next;

    // maps and output
    logic [SCR_N-1:0]  screen_reg, screen_next;
    logic [TW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_free_reg, m_free_next;

    // divider hookup
    logic              div_start, div_busy;
    logic [POS_W-1:0]  div_dividend, div_quotient;
    logic [CFG_W-1:0]  div_divisor;

    // tile memory hookup
    tmem_cmd_t              tm_cmd;
    logic [TW-1:0]          tm_addr, tm_bit;
    logic [TILE_MAP_SIDE-1:0] tm_rdata;

    // derived
    logic              accept;
    logic [TILE_W-1:0] tx0, tx1, ty0, ty1;
    logic              tx_in, ty_in, tile_solid;
    logic [SIW-1:0]    scr_idx, scr_widx;
    logic              scr_hit, scr_last;
    logic              scr_wr_ok, tile_wr_ok;

    assign s_tready  = (ctrl.uop == UOP_ACCEPT);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // tile index ranges: right and bottom ends wrap at 16 bits
    assign tx0 = px_reg[POS_W-1:TILE_SHIFT];
    assign tx1 = x1_reg[POS_W-1:TILE_SHIFT];
    assign ty0 = py_reg[POS_W-1:TILE_SHIFT];
    assign ty1 = y1_reg[POS_W-1:TILE_SHIFT];

    // tiles off the map read as open
    assign tx_in      = 32'(tx_reg) < 32'(TILE_MAP_SIDE);
    assign ty_in      = 32'(ty_reg) < 32'(TILE_MAP_SIDE);
    assign tile_solid = tx_in && ty_in && tm_rdata[TW'(tx_reg)];

    assign scr_idx  = SIW'(32'(row_reg) * 32'(SCREEN_GRID) + 32'(col_reg));
    assign scr_widx = SIW'(32'(cy_reg) * 32'(SCREEN_GRID) + 32'(cx_reg));
    assign scr_hit  = screen_reg[scr_idx];
    assign scr_last = (col_reg == GW'(c1_reg)) && (row_reg == GW'(r1_reg));

    assign scr_wr_ok  = (32'(cx_reg) < 32'(SCREEN_GRID)) && (32'(cy_reg) < 32'(SCREEN_GRID));
    assign tile_wr_ok = (32'(cx_reg) < 32'(TILE_MAP_SIDE))
                     && (32'(cy_reg) < 32'(TILE_MAP_SIDE));

    // status to the sequencer
    always_comb begin
        flags.clr_more   = clr_cnt_reg != TW'(TILE_MAP_SIDE - 1);
        flags.no_req     = !s_tvalid;
        flags.op_screen  = op_reg == OP_WR_SCREEN;
        flags.op_tile    = op_reg == OP_WR_TILE;
        flags.not_query  = op_reg != OP_QUERY;
        flags.bad_size   = (bw_reg == '0) || (bh_reg == '0) || (sw_reg == '0) || (sh_reg == '0);
        flags.div_busy   = div_busy;
        flags.scr_empty  = (c0_reg > c1_reg) || (r0_reg > r1_reg);
        flags.scr_oor    = (c1_reg > POS_W'(SCREEN_GRID - 1)) || (r1_reg > POS_W'(SCREEN_GRID - 1));
        flags.scr_step   = !scr_last && scr_hit;
        flags.scr_miss   = !scr_hit;
        flags.tile_empty = (tx0 > tx1) || (ty0 > ty1);
        flags.x_step     = (tx_reg != tx1) && !tile_solid;
        flags.tile_solid = tile_solid;
        flags.y_more     = ty_reg != ty1;
        flags.out_full   = m_valid_reg && !m_tready;
    end

    // divider operand select
    always_comb begin
        case (ctrl.dsel)
            DIV_C0:  div_dividend = px_reg;
            DIV_C1:  div_dividend = x1_reg;
            DIV_R0:  div_dividend = py_reg;
            DIV_R1:  div_dividend = y1_reg;
            default: div_dividend = px_reg;
        endcase
        div_divisor = ((ctrl.dsel == DIV_C0) || (ctrl.dsel == DIV_C1)) ? sw_reg : sh_reg;
    end

    // datapath, driven by the current control word
    always_comb begin
        sw_next      = sw_reg;
        sh_next      = sh_reg;
        op_next      = op_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        bw_next      = bw_reg;
        bh_next      = bh_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        bv_next      = bv_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        c0_next      = c0_reg;
        c1_next      = c1_reg;
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        free_next    = free_reg;
        screen_next  = screen_reg;
        clr_cnt_next = clr_cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_free_next  = m_free_reg;
        div_start    = 1'b0;
        tm_cmd       = '0;
        tm_addr      = TW'(ty_reg);
        tm_bit       = TW'(cx_reg);

        if (cfg_valid) begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  sw_next = cfg_data;
                CFG_SCREEN_HEIGHT: sh_next = cfg_data;
                default:           sw_next = sw_reg;
            endcase
        end

        case (ctrl.uop)
            UOP_CLEAR: begin
                tm_cmd.clr   = 1'b1;
                tm_addr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            UOP_ACCEPT: begin
                if (accept) begin
                    op_next = s_tuser;
                    px_next = s_tdata[PX_LSB +: POS_W];
                    py_next = s_tdata[PY_LSB +: POS_W];
                    bw_next = s_tdata[BW_LSB +: SIZE_W];
                    bh_next = s_tdata[BH_LSB +: SIZE_W];
                    cx_next = s_tdata[CX_LSB +: CELL_W];
                    cy_next = s_tdata[CY_LSB +: CELL_W];
                    bv_next = s_tdata[BV_LSB];
                end
            end
            UOP_PREP: begin
                x1_next   = px_reg + POS_W'(bw_reg) - 1'b1;
                y1_next   = py_reg + POS_W'(bh_reg) - 1'b1;
                free_next = 1'b0;
            end
            UOP_DIV_START: begin
                div_start = 1'b1;
            end
            UOP_DIV_WAIT: begin
                if (!div_busy) begin
                    case (ctrl.dsel)
                        DIV_C0:  c0_next = div_quotient;
                        DIV_C1:  c1_next = div_quotient;
                        DIV_R0:  r0_next = div_quotient;
                        DIV_R1:  r1_next = div_quotient;
                        default: c0_next = div_quotient;
                    endcase
                end
            end
            UOP_SCR_INIT: begin
                col_next = GW'(c0_reg);
                row_next = GW'(r0_reg);
            end
            UOP_SCR_SCAN: begin
                // walk rows inside a column, then step the column
                if (flags.scr_step) begin
                    if (row_reg != GW'(r1_reg)) begin
                        row_next = row_reg + 1'b1;
                    end else begin
                        row_next = GW'(r0_reg);
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            UOP_TILE_INIT: begin
                tx_next = tx0;
                ty_next = ty0;
            end
            UOP_ROW_READ: begin
                tm_cmd.rd = 1'b1;
            end
            UOP_TILE_SCAN: begin
                if (flags.x_step) begin
                    tx_next = tx_reg + 1'b1;
                end
            end
            UOP_TILE_NEXT_Y: begin
                if (flags.y_more) begin
                    ty_next = ty_reg + 1'b1;
                    tx_next = tx0;
                end
            end
            UOP_SET_FREE: begin
                free_next = 1'b1;
            end
            UOP_EMIT: begin
                if (!flags.out_full) begin
                    m_valid_next = 1'b1;
                    m_free_next  = free_reg;
                end
            end
            UOP_WR_SCREEN: begin
                if (scr_wr_ok) begin
                    screen_next[scr_widx] = bv_reg;
                end
            end
            UOP_WR_TILE: begin
                tm_addr        = TW'(cy_reg);
                tm_cmd.wr      = tile_wr_ok;
                tm_cmd.bit_val = bv_reg;
            end
            default: begin
                tm_cmd = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg      <= SCREEN_W_RST;
            sh_reg      <= SCREEN_H_RST;
            screen_reg  <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sw_reg      <= sw_next;
            sh_reg      <= sh_next;
            screen_reg  <= screen_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        bw_reg     <= bw_next;
        bh_reg     <= bh_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        bv_reg     <= bv_next;
        x1_reg     <= x1_next;
        y1_reg     <= y1_next;
        c0_reg     <= c0_next;
        c1_reg     <= c1_next;
        r0_reg     <= r0_next;
        r1_reg     <= r1_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        free_reg   <= free_next;
        m_free_reg <= m_free_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 1){1'b0}}, m_free_reg};

    bvtc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    bvtc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    bvtc_tmem #(
        .TILE_MAP_SIDE (TILE_MAP_SIDE)
    ) u_tmem (
        .aclk    (aclk),
        .cmd     (tm_cmd),
        .addr    (tm_addr),
        .bit_sel (tm_bit),
        .rdata   (tm_rdata)
    );

    // screen scan only runs once the range is known to fit the grid
    `BVTC_ASSERT_NOW(a_scr_in_grid, ctrl.uop == UOP_SCR_SCAN, (c1_reg < POS_W'(SCREEN_GRID)) && (r1_reg < POS_W'(SCREEN_GRID)), "screen scan outside grid")
    // a result appears only from the emit step
    `BVTC_ASSERT_NOW(a_emit_src, $past(aresetn) && $rose(m_valid_reg), $past(ctrl.uop == UOP_EMIT), "result raised outside emit step")

endmodule

// ===== hdl/bvtc_div.sv =====
`include "box_vs_tilemap_collision_unit_macros.svh"

// Restoring divider, one quotient bit per cycle.
module bvtc_div
    import bvtc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [CFG_W-1:0] divisor,
    output logic             busy,
    output logic [POS_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0]     quo_reg, quo_next;
    logic [CFG_W-1:0]     rem_reg, rem_next;
    logic [CFG_W-1:0]     dvs_reg, dvs_next;
    logic [CFG_W:0]       shifted;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[POS_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? CFG_W'(shifted - {1'b0, dvs_reg}) : CFG_W'(shifted);
            quo_next = {quo_reg[POS_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    // a run always takes the full count of steps
    `BVTC_ASSERT_NOW(a_div_len, $past(aresetn) && $fell(busy_reg), $past(cnt_reg) == DIV_CNT_W'(DIV_STEPS - 1), "divider finished early")

endmodule

// ===== hdl/bvtc_tmem.sv =====
// Solid tile bit map: one row of tiles per word.
module bvtc_tmem
    import bvtc_pkg::*;
#(
    parameter int TILE_MAP_SIDE = TILE_MAP_SIDE_DEF
) (
    input  logic                             aclk,
    input  tmem_cmd_t                        cmd,
    input  logic [$clog2(TILE_MAP_SIDE)-1:0] addr,
    input  logic [$clog2(TILE_MAP_SIDE)-1:0] bit_sel,
    output logic [TILE_MAP_SIDE-1:0]         rdata
);

    logic [TILE_MAP_SIDE-1:0] mem [TILE_MAP_SIDE];
    logic [TILE_MAP_SIDE-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            mem[addr] <= '0;
        end else if (cmd.wr) begin
            mem[addr][bit_sel] <= cmd.bit_val;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bvtc_seq.sv =====
`include "box_vs_tilemap_collision_unit_macros.svh"

// Microprogram sequencer: step counter, control store, conditional jump.
module bvtc_seq
    import bvtc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  flags_t flags,
    output ucode_t ctrl
);

    pc_t  pc_reg, pc_next;
    logic take;

    assign ctrl = ucode_rom(pc_reg);

    always_comb begin
        case (ctrl.cond)
            COND_NEVER:      take = 1'b0;
            COND_ALWAYS:     take = 1'b1;
            COND_CLR_MORE:   take = flags.clr_more;
            COND_NO_REQ:     take = flags.no_req;
            COND_OP_SCREEN:  take = flags.op_screen;
            COND_OP_TILE:    take = flags.op_tile;
            COND_NOT_QUERY:  take = flags.not_query;
            COND_BAD_SIZE:   take = flags.bad_size;
            COND_DIV_BUSY:   take = flags.div_busy;
            COND_SCR_EMPTY:  take = flags.scr_empty;
            COND_SCR_OOR:    take = flags.scr_oor;
            COND_SCR_STEP:   take = flags.scr_step;
            COND_SCR_MISS:   take = flags.scr_miss;
            COND_TILE_EMPTY: take = flags.tile_empty;
            COND_X_STEP:     take = flags.x_step;
            COND_TILE_SOLID: take = flags.tile_solid;
            COND_Y_MORE:     take = flags.y_more;
            COND_OUT_FULL:   take = flags.out_full;
            default:         take = 1'b0;
        endcase
    end

    always_comb begin
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_CLEAR;
        end else begin
            pc_reg <= pc_next;
        end
    end

    `BVTC_ASSERT_NOW(a_pc_range, 1'b1, pc_reg <= PC_LAST, "step counter left the program")
    `BVTC_ASSERT_NEXT(a_dispatch, (ctrl.uop == UOP_ACCEPT) && !flags.no_req, pc_reg == PC_ACCEPT + 1'b1, "accepted request not dispatched")

endmodule
